/* rtl/ptq_pkg.sv */
package ptq_pkg;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]  prio;
        logic [7:0]  id;
        logic [15:0] burst;
    } slot_t;

    typedef struct packed {
        logic  valid;
        logic  keep;
        slot_t data;
    } link_t;

    typedef struct packed {
        logic  insert;
        logic  dispatch;
        slot_t fresh;
    } cmd_t;

endpackage

/* rtl/ptq_cell.sv */
module ptq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ptq_pkg::cmd_t  cmd,
    input  ptq_pkg::link_t left,
    input  ptq_pkg::link_t right,
    output ptq_pkg::link_t self
);
    import ptq_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    slot_t data_reg;
    slot_t data_next;
    logic  keep;

    assign keep = valid_reg && (data_reg.prio >= cmd.fresh.prio);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.insert)
        begin
            valid_next = valid_reg || left.valid;
            if (!keep)
            begin
                data_next = left.keep ? cmd.fresh : left.data;
            end
        end
        else if (cmd.dispatch)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign self.valid = valid_reg;
    assign self.keep  = keep;
    assign self.data  = data_reg;

endmodule

/* rtl/priority_task_queue.sv */
// Stable priority task queue of QUEUE_DEPTH slots kept as a row of cells sorted by
// descending priority, ties in arrival order, head in cell 0. Every cell updates in
// parallel from its neighbors, so one item (insert or dispatch) is taken per cycle and
// its result appears in the output register in the next cycle; the input stalls only
// while that register holds a result the consumer is stalling. An insert into a full
// queue is dropped with status full; a dispatch from an empty queue reports empty.
// On a dispatch, finish_time is the saturating sum of bursts dispatched since reset.
module priority_task_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  task_id,
    input  logic [3:0]  task_priority,
    input  logic [15:0] task_burst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_task_id,
    output logic [3:0]  out_priority,
    output logic [15:0] out_burst,
    output logic [31:0] finish_time
);
    import ptq_pkg::*;

    link_t cell_link [QUEUE_DEPTH];
    link_t head_edge;
    link_t tail_edge;
    cmd_t  cmd;

    logic        accept;
    logic        full;
    logic        empty;
    logic [32:0] sum;

    logic        out_valid_reg;
    logic        out_valid_next;
    status_t     status_reg;
    status_t     status_next;
    slot_t       result_reg;
    slot_t       result_next;
    logic [31:0] finish_reg;
    logic [31:0] finish_next;
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = cell_link[QUEUE_DEPTH-1].valid;
    assign empty    = !cell_link[0].valid;

    assign cmd.insert      = accept && (operation == OP_INSERT) && !full;
    assign cmd.dispatch    = accept && (operation == OP_DISPATCH) && !empty;
    assign cmd.fresh.prio  = task_priority;
    assign cmd.fresh.id    = task_id;
    assign cmd.fresh.burst = task_burst;

    assign head_edge = '{valid: 1'b1, keep: 1'b1, data: '0};
    assign tail_edge = '{valid: 1'b0, keep: 1'b0, data: '0};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        link_t left_link;
        link_t right_link;
        if (i == 0)
        begin : g_head
            assign left_link = head_edge;
        end
        else
        begin : g_mid
            assign left_link = cell_link[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_link = tail_edge;
        end
        else
        begin : g_body
            assign right_link = cell_link[i+1];
        end
        ptq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_link),
            .right (right_link),
            .self  (cell_link[i])
        );
    end

    assign sum = {1'b0, elapsed_reg} + {17'b0, cell_link[0].data.burst};

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        result_next    = result_reg;
        finish_next    = finish_reg;
        elapsed_next   = elapsed_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            result_next    = '0;
            finish_next    = '0;
            if (operation == OP_INSERT)
            begin
                status_next = full ? ST_FULL : ST_INSERTED;
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next  = ST_DISPATCHED;
                result_next  = cell_link[0].data;
                elapsed_next = sum[32] ? '1 : sum[31:0];
                finish_next  = elapsed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            elapsed_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        finish_reg <= finish_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_task_id  = result_reg.id;
    assign out_priority = result_reg.prio;
    assign out_burst    = result_reg.burst;
    assign finish_time  = finish_reg;

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cell_link[1].valid |-> cell_link[0].valid)
        else $error("occupied slots do not form a prefix");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_link[1].valid |-> cell_link[0].data.prio >= cell_link[1].data.prio)
        else $error("head priority below its successor");

    a_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time decreased");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == OP_INSERT && full |=> out_valid_reg && status_reg == ST_FULL)
        else $error("insert into full queue not reported as dropped");

endmodule

/* dv/ptq_checker.sv */
`timescale 1ns / 1ps

module ptq_checker
    import ptq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  task_id,
    input  logic [3:0]  task_priority,
    input  logic [15:0] task_burst,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [7:0]  out_task_id,
    input  logic [3:0]  out_priority,
    input  logic [15:0] out_burst,
    input  logic [31:0] finish_time,
    output int          errors,
    output int          pending,
    output int          n_inserted,
    output int          n_dropped,
    output int          n_dispatched,
    output int          n_empty,
    output logic        saw_saturation
);

    typedef struct packed {
        status_t     st;
        logic [7:0]  id;
        logic [3:0]  prio;
        logic [15:0] burst;
        logic [31:0] finish;
    } outcome_t;

    slot_t       queue_slots [DEPTH];
    int          occupancy;
    logic [31:0] burst_total;
    outcome_t    awaited [$];
    outcome_t    oldest;

    task automatic schedule_item(input logic op, input logic [7:0] id,
                                 input logic [3:0] prio, input logic [15:0] burst);
        outcome_t    res;
        slot_t       head;
        int          pos;
        logic [32:0] sum;
        res = '0;
        if (op == OP_INSERT)
        begin
            if (occupancy >= DEPTH)
            begin
                res.st = ST_FULL;
                n_dropped++;
            end
            else
            begin
                // go behind every task of the same or higher priority
                pos = 0;
                while (pos < occupancy && queue_slots[pos].prio >= prio)
                    pos++;
                for (int k = occupancy; k > pos; k--)
                    queue_slots[k] = queue_slots[k - 1];
                queue_slots[pos].prio  = prio;
                queue_slots[pos].id    = id;
                queue_slots[pos].burst = burst;
                occupancy++;
                res.st = ST_INSERTED;
                n_inserted++;
            end
        end
        else if (occupancy == 0)
        begin
            res.st = ST_EMPTY;
            n_empty++;
        end
        else
        begin
            head = queue_slots[0];
            sum = {1'b0, burst_total} + {17'b0, head.burst};
            burst_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            for (int k = 0; k + 1 < occupancy; k++)
                queue_slots[k] = queue_slots[k + 1];
            occupancy--;
            res.st     = ST_DISPATCHED;
            res.id     = head.id;
            res.prio   = head.prio;
            res.burst  = head.burst;
            res.finish = burst_total;
            n_dispatched++;
            if (burst_total == 32'hFFFF_FFFF)
                saw_saturation = 1'b1;
        end
        awaited.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited.delete();
            occupancy      = 0;
            burst_total    = '0;
            errors         = 0;
            pending        = 0;
            n_inserted     = 0;
            n_dropped      = 0;
            n_dispatched   = 0;
            n_empty        = 0;
            saw_saturation = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                schedule_item(operation, task_id, task_priority, task_burst);
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result with no item pending: status %0d", status);
                    errors++;
                end
                else
                begin
                    oldest = awaited.pop_front();
                    if (status !== oldest.st)
                    begin
                        $error("status expected %0d got %0d", oldest.st, status);
                        errors++;
                    end
                    if (out_task_id !== oldest.id)
                    begin
                        $error("out_task_id expected %0d got %0d", oldest.id, out_task_id);
                        errors++;
                    end
                    if (out_priority !== oldest.prio)
                    begin
                        $error("out_priority expected %0d got %0d", oldest.prio, out_priority);
                        errors++;
                    end
                    if (out_burst !== oldest.burst)
                    begin
                        $error("out_burst expected %0d got %0d", oldest.burst, out_burst);
                        errors++;
                    end
                    if (finish_time !== oldest.finish)
                    begin
                        $error("finish_time expected %0d got %0d", oldest.finish, finish_time);
                        errors++;
                    end
                end
            end
            pending = awaited.size();
        end
    end

endmodule

/* dv/tb_priority_task_queue.sv */
`timescale 1ns / 1ps

module tb_priority_task_queue;
    import ptq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int LONG_HOLD    = 80;
    localparam int ITEM_TARGET  = 520;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  task_id;
    logic [3:0]  task_priority;
    logic [15:0] task_burst;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  out_task_id;
    logic [3:0]  out_priority;
    logic [15:0] out_burst;
    logic [31:0] finish_time;

    int          errors;
    int          pending;
    int          n_inserted;
    int          n_dropped;
    int          n_dispatched;
    int          n_empty;
    logic        saw_saturation;

    bit          quiet;
    bit          hold_req;
    int          items_sent;

    priority_task_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .task_id       (task_id),
        .task_priority (task_priority),
        .task_burst    (task_burst),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_task_id   (out_task_id),
        .out_priority  (out_priority),
        .out_burst     (out_burst),
        .finish_time   (finish_time)
    );

    ptq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .task_id        (task_id),
        .task_priority  (task_priority),
        .task_burst     (task_burst),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_task_id    (out_task_id),
        .out_priority   (out_priority),
        .out_burst      (out_burst),
        .finish_time    (finish_time),
        .errors         (errors),
        .pending        (pending),
        .n_inserted     (n_inserted),
        .n_dropped      (n_dropped),
        .n_dispatched   (n_dispatched),
        .n_empty        (n_empty),
        .saw_saturation (saw_saturation)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_burst();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_item(input logic op, input logic [7:0] id,
                             input logic [3:0] prio, input logic [15:0] burst);
        int gap;
        in_valid      <= 1'b1;
        operation     <= op;
        task_id       <= id;
        task_priority <= prio;
        task_burst    <= burst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_insert(input logic [3:0] span);
        send_item(OP_INSERT, 8'($urandom_range(0, 255)), 4'($urandom_range(0, span)),
                  rand_burst());
    endtask

    task automatic send_dispatch();
        send_item(OP_DISPATCH, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                hold = pick_gap();
            @(negedge clk);
            out_stall <= (hold > 0);
            if (hold > 1)
                repeat (hold - 1) @(negedge clk);
        end
    end

    initial
    begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  seg_len;
        int  kind;
        int  span;
        bit  pressed;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_INSERT;
        task_id       = '0;
        task_priority = '0;
        task_burst    = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        pressed       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_DISPATCH, 8'h00, 4'h0, 16'h0000);
        send_item(OP_INSERT, 8'hA5, 4'd5, 16'd100);
        send_item(OP_INSERT, 8'h5A, 4'd5, 16'd200);
        send_item(OP_INSERT, 8'h01, 4'd3, 16'h0000);
        send_item(OP_INSERT, 8'hFF, 4'hF, 16'hFFFF);
        send_item(OP_INSERT, 8'h00, 4'h0, 16'h8001);
        send_item(OP_INSERT, 8'h7E, 4'd5, 16'h7FFE);
        send_item(OP_INSERT, 8'h81, 4'hF, 16'h0001);
        repeat (8) send_dispatch();
        send_item(OP_INSERT, 8'h10, 4'd9, 16'd5);
        send_item(OP_INSERT, 8'h11, 4'd2, 16'd6);
        send_item(OP_INSERT, 8'h12, 4'd9, 16'd7);
        repeat (4) send_dispatch();

        while (items_sent < ITEM_TARGET)
        begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(4, 24);
            span    = ($urandom_range(0, 1) == 1) ? 15 : $urandom_range(0, 3);
            quiet   = ($urandom_range(0, 4) == 0);
            if (!pressed && items_sent > 250)
            begin
                // hold off the output until the queue backs up into the input
                wait_drained();
                quiet    = 1'b1;
                hold_req = 1'b1;
                repeat (2 * DEPTH) send_insert(4'(span));
                pressed = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
                wait_drained();
            for (int i = 0; i < seg_len; i++)
            begin
                if (kind < 3)
                    send_insert(4'(span));
                else if (kind < 5)
                    send_dispatch();
                else if ($urandom_range(0, 99) < 55)
                    send_insert(4'(span));
                else
                    send_dispatch();
            end
        end

        // empty the queue and read past its end
        wait_drained();
        quiet = 1'b1;
        repeat (DEPTH + 2) send_dispatch();

        wait_drained();
        repeat (8) @(negedge clk);
        $display("Covered %0d inserts, %0d drops on a full queue, %0d dispatches, %0d empty reads",
                 n_inserted, n_dropped, n_dispatched, n_empty);
        $display("Finish time saturation reached: %s", saw_saturation ? "yes" : "no");
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
